### rtl/core/hvn_pkg.sv
`default_nettype none
package hvn_pkg;

  // Saturation bounds of the 27-bit signed position fields
  localparam int POS_MAX = 67108863;
  localparam int POS_MIN = -67108864;

  localparam logic [14:0] MAG_MAX = 15'd32767;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_SPACING = 2'd2
  } cfg_idx_t;

  // Request to the normalize unit: 32768*a/sqrt(s), rounded, saturated
  typedef struct packed {
    logic        start;
    logic [7:0]  a;
    logic [16:0] s;
  } nrm_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [14:0] mag;
  } nrm_rsp_t;

endpackage
`default_nettype wire

### rtl/core/hvn_line_store.sv
`default_nettype none
module hvn_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    older_wdata,
  input  wire logic [7:0]    newer_wdata,
  output logic [7:0]         older_q,
  output logic [7:0]         newer_q
);

  logic [7:0] older_mem [DEPTH];
  logic [7:0] newer_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= older_wdata;
      newer_mem[wr_addr] <= newer_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_q <= older_mem[rd_addr];
      newer_q <= newer_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/hvn_norm_unit.sv
`default_nettype none
module hvn_norm_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hvn_pkg::nrm_req_t req,
  output hvn_pkg::nrm_rsp_t      rsp
);
  import hvn_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE = 3'b001,
    N_DIV  = 3'b010,
    N_SQRT = 3'b100
  } nstate_t;

  nstate_t     state;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [16:0] rem;
  logic [16:0] s_q;
  logic [32:0] quo;
  logic [32:0] x;
  logic [33:0] r;
  logic [33:0] b;
  logic        done;
  logic [14:0] mag;

  logic [17:0] sh;
  logic        qbit;
  logic [33:0] rb;
  logic        take;
  logic [33:0] r_next;
  logic [17:0] n_rnd;

  always_comb begin
    sh     = {rem, dvd[47]};
    qbit   = (sh >= {1'b0, s_q});
    rb     = r + b;
    take   = ({1'b0, x} >= rb);
    r_next = take ? ((r >> 1) + b) : (r >> 1);
    n_rnd  = (18'(r_next[16:0]) + 18'd1) >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == N_SQRT) && (cnt == 6'd0);
      unique case (state)
        N_IDLE: begin
          if (req.start) begin
            dvd   <= {16'(req.a * req.a), 32'd0};
            rem   <= '0;
            quo   <= '0;
            s_q   <= req.s;
            cnt   <= 6'd47;
            state <= N_DIV;
          end
        end
        N_DIV: begin
          rem <= qbit ? 17'(sh - {1'b0, s_q}) : sh[16:0];
          quo <= {quo[31:0], qbit};
          dvd <= dvd << 1;
          if (cnt == 6'd0) begin
            x     <= {quo[31:0], qbit};
            r     <= '0;
            b     <= 34'd1 << 32;
            cnt   <= 6'd16;
            state <= N_SQRT;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        N_SQRT: begin
          if (take) x <= 33'(({1'b0, x}) - rb);
          r <= r_next;
          b <= b >> 2;
          if (cnt == 6'd0) begin
            mag   <= (n_rnd > 18'(MAG_MAX)) ? MAG_MAX : n_rnd[14:0];
            state <= N_IDLE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state != N_IDLE);
  assign rsp.done = done;
  assign rsp.mag  = mag;

endmodule
`default_nettype wire

### rtl/core/heightmap_vertex_normal_stream_core.sv
`default_nettype none
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    height_sample
// out       out  out_valid/out_ready  vertex_row .. frame_done
// cfg       in   cfg_we               cfg_index, cfg_data
//
// Each pixel passes through the line-store read/write states (RD0, RD1, RD2), and each
// emitted vertex adds a pick state, three normal components through one shared
// normalize unit (each: start, 48-step divide, 17-step root, handoff) and a load
// state. Row 0 pixels emit no vertex; last-row pixels can emit up to 3 vertices.
// The load stalls while out_ready stays low on a full output register.
// Reset is synchronous; line stores hold no reset state.
// A finished vertex waits in the output register while the next pixel is taken.
module heightmap_vertex_normal_stream_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  height_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       vertex_row,
  output logic [9:0]       vertex_col,
  output logic signed [26:0] x_pos,
  output logic [7:0]       y_height,
  output logic signed [26:0] z_pos,
  output logic signed [15:0] normal_x,
  output logic [14:0]      normal_y,
  output logic signed [15:0] normal_z,
  output logic             run_last,
  output logic             frame_done,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import hvn_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW  = (CW > RW) ? CW : RW;
  localparam int PW  = ((MW > 11) ? MW : 11) + 3;
  localparam int PPW = PW + 17;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD0  = 7'b0000010,
    ST_RD1  = 7'b0000100,
    ST_RD2  = 7'b0001000,
    ST_PICK = 7'b0010000,
    ST_NRM  = 7'b0100000,
    ST_LOAD = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    CMP_X = 2'd0,
    CMP_Y = 2'd1,
    CMP_Z = 2'd2
  } comp_t;

  typedef struct packed {
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [7:0]    self_h;
    logic [7:0]    left_h;
    logic [7:0]    right_h;
    logic [7:0]    up_h;
    logic [7:0]    down_h;
    logic          last_vtx;
  } job_t;

  state_t        state;
  logic [10:0]   map_width;
  logic [10:0]   map_height;
  logic [15:0]   grid_spacing;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [7:0]    smp;
  logic [7:0]    prev_sample;
  logic [7:0]    prev2;
  logic [7:0]    prev_self;
  logic [7:0]    self_q;
  logic [7:0]    up_q;
  job_t          slot [3];
  logic [1:0]    njobs;
  logic [1:0]    jidx;
  job_t          cur;
  logic signed [8:0]  dx_q;
  logic signed [8:0]  dz_q;
  logic [16:0]   s_q;
  logic signed [PW-1:0]  xsteps;
  logic signed [PW-1:0]  zsteps;
  logic signed [PPW-1:0] px;
  logic signed [PPW-1:0] pz;
  comp_t         comp;
  logic          launch;
  logic [14:0]   mag_x;
  logic [14:0]   mag_y;
  logic [14:0]   mag_z;

  logic [7:0]    older_q;
  logic [7:0]    newer_q;
  nrm_req_t      nrm_req;
  nrm_rsp_t      nrm_rsp;

  logic [10:0]   ew;
  logic [10:0]   eh;
  logic          last_col;
  logic          last_row;
  logic          j1v;
  logic          j2v;
  job_t          j0;
  job_t          j1;
  job_t          j2;
  job_t          pick;
  logic signed [8:0] dx_c;
  logic signed [8:0] dz_c;
  logic [CW-1:0] c_plus;

  always_comb begin
    if (map_width == 11'd0) ew = 11'd1;
    else if (32'(map_width) > MAX_WIDTH) ew = 11'(MAX_WIDTH);
    else ew = map_width;
    if (map_height < 11'd2) eh = 11'd2;
    else if (32'(map_height) > MAX_HEIGHT) eh = 11'(MAX_HEIGHT);
    else eh = map_height;
    last_col = (32'(c) + 32'd1 >= 32'(ew));
    last_row = (32'(r) + 32'd1 >= 32'(eh));
    c_plus   = CW'(32'(c) + 32'd1);
    j1v      = last_row && (c != '0);
    j2v      = last_row && last_col;

    // vertex of the previous row at this column
    j0.row      = RW'(32'(r) - 32'd1);
    j0.col      = c;
    j0.self_h   = self_q;
    j0.left_h   = (c != '0) ? prev_self : self_q;
    j0.right_h  = (!last_col && (32'(c) + 32'd1 < MAX_WIDTH)) ? newer_q : self_q;
    j0.up_h     = (r > RW'(1)) ? up_q : self_q;
    j0.down_h   = smp;
    j0.last_vtx = 1'b0;

    // last row: vertex one column back
    j1.row      = r;
    j1.col      = CW'(32'(c) - 32'd1);
    j1.self_h   = prev_sample;
    j1.left_h   = (c > CW'(1)) ? prev2 : prev_sample;
    j1.right_h  = smp;
    j1.up_h     = prev_self;
    j1.down_h   = prev_sample;
    j1.last_vtx = 1'b0;

    // last row, last column: the closing vertex
    j2.row      = r;
    j2.col      = c;
    j2.self_h   = smp;
    j2.left_h   = (c != '0) ? prev_sample : smp;
    j2.right_h  = smp;
    j2.up_h     = self_q;
    j2.down_h   = smp;
    j2.last_vtx = 1'b1;

    pick = slot[jidx];
    dx_c = $signed({1'b0, pick.right_h}) - $signed({1'b0, pick.left_h});
    dz_c = $signed({1'b0, pick.down_h}) - $signed({1'b0, pick.up_h});
  end

  hvn_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk         (clk),
    .rd_en       ((state == ST_RD0) || (state == ST_RD1)),
    .rd_addr     ((state == ST_RD0) ? c : c_plus),
    .wr_en       (state == ST_RD2),
    .wr_addr     (c),
    .older_wdata (self_q),
    .newer_wdata (smp),
    .older_q     (older_q),
    .newer_q     (newer_q)
  );

  always_comb begin
    nrm_req.start = launch;
    unique case (comp)
      CMP_X:   nrm_req.a = dx_q[8] ? 8'(-dx_q) : dx_q[7:0];
      CMP_Y:   nrm_req.a = 8'd1;
      CMP_Z:   nrm_req.a = dz_q[8] ? 8'(-dz_q) : dz_q[7:0];
      default: nrm_req.a = 8'd1;
    endcase
    nrm_req.s = s_q;
  end

  hvn_norm_unit u_norm (
    .clk (clk),
    .rst (rst),
    .req (nrm_req),
    .rsp (nrm_rsp)
  );

  function automatic logic [26:0] sat_pos(input logic signed [PPW-1:0] v);
    logic [26:0] res;
    if (v > $signed(PPW'(POS_MAX))) res = 27'(POS_MAX);
    else if (v < $signed(PPW'(POS_MIN))) res = 27'(POS_MIN);
    else res = v[26:0];
    return res;
  endfunction

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      map_width    <= 11'd1024;
      map_height   <= 11'd1024;
      grid_spacing <= 16'd256;
      c            <= '0;
      r            <= '0;
      prev_sample  <= '0;
      out_valid    <= 1'b0;
      launch       <= 1'b0;
      comp         <= CMP_X;
      jidx         <= '0;
      njobs        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:   map_width    <= cfg_data[10:0];
          CFG_HEIGHT:  map_height   <= cfg_data[10:0];
          CFG_SPACING: grid_spacing <= cfg_data;
          default: ;
        endcase
      end
      if ((state == ST_LOAD) && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            smp   <= height_sample;
            state <= ST_RD0;
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          self_q <= newer_q;
          up_q   <= older_q;
          state  <= ST_RD2;
        end
        ST_RD2: begin
          slot[0]     <= j0;
          slot[1]     <= j1v ? j1 : j2;
          slot[2]     <= j2;
          njobs       <= (r == '0) ? 2'd0 : 2'(2'd1 + 2'(j1v) + 2'(j2v));
          jidx        <= '0;
          prev2       <= prev_sample;
          prev_sample <= smp;
          prev_self   <= self_q;
          if (last_col) begin
            c <= '0;
            r <= last_row ? '0 : RW'(32'(r) + 32'd1);
          end else begin
            c <= c_plus;
          end
          state <= (r != '0) ? ST_PICK : ST_IDLE;
        end
        ST_PICK: begin
          cur    <= pick;
          dx_q   <= dx_c;
          dz_q   <= dz_c;
          s_q    <= 17'(dx_c * dx_c) + 17'(dz_c * dz_c) + 17'd1;
          xsteps <= $signed(PW'({pick.col, 1'b0})) - $signed(PW'(ew));
          zsteps <= $signed(PW'({pick.row, 1'b0})) + $signed(PW'(2)) - $signed(PW'(eh));
          comp   <= CMP_X;
          launch <= 1'b1;
          state  <= ST_NRM;
        end
        ST_NRM: begin
          px     <= PPW'(xsteps) * $signed(PPW'({1'b0, grid_spacing}));
          pz     <= PPW'(zsteps) * $signed(PPW'({1'b0, grid_spacing}));
          launch <= nrm_rsp.done && (comp != CMP_Z);
          if (nrm_rsp.done) begin
            unique case (comp)
              CMP_X: begin
                mag_x <= nrm_rsp.mag;
                comp  <= CMP_Y;
              end
              CMP_Y: begin
                mag_y <= nrm_rsp.mag;
                comp  <= CMP_Z;
              end
              default: begin
                mag_z <= nrm_rsp.mag;
                state <= ST_LOAD;
              end
            endcase
          end
        end
        ST_LOAD: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            vertex_row <= 10'(cur.row);
            vertex_col <= 10'(cur.col);
            x_pos      <= sat_pos(px);
            y_height   <= cur.self_h;
            z_pos      <= sat_pos(pz);
            normal_x   <= dx_q[8] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
            normal_y   <= mag_y;
            normal_z   <= dz_q[8] ? -$signed({1'b0, mag_z}) : $signed({1'b0, mag_z});
            run_last   <= (jidx == 2'(njobs - 2'd1));
            frame_done <= cur.last_vtx;
            if (jidx == 2'(njobs - 2'd1)) begin
              state <= ST_IDLE;
            end else begin
              jidx  <= jidx + 2'd1;
              state <= ST_PICK;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RD0))
    else $error("accepted pixel did not start a store read");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |-> (jidx < njobs))
    else $error("vertex slot index past job count");

  a_frame_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> run_last)
    else $error("frame_done beat is not the last of its pixel");

  a_norm_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !nrm_rsp.busy)
    else $error("normalize unit busy while idle");

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import hvn_pkg::*;

  typedef struct packed {
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [26:0] xp;
    logic [7:0]         yh;
    logic signed [26:0] zp;
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic               rl;
    logic               fd;
  } vertex_t;

  localparam int ROW_MAX  = 1024;
  localparam int DOG_MAX  = 4000;
  localparam int SETTLE   = 700;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] height_sample = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [9:0] vertex_row, vertex_col;
  logic signed [26:0] x_pos, z_pos;
  logic [7:0] y_height;
  logic signed [15:0] normal_x, normal_z;
  logic [14:0] normal_y;
  logic run_last, frame_done;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  always #2 clk = ~clk;

  heightmap_vertex_normal_stream_core u_top (.*);

  // mirror of the block state
  int unsigned width_reg = 1024, height_reg = 1024, spacing_reg = 256;
  logic [7:0] older_line [ROW_MAX];
  logic [7:0] newer_line [ROW_MAX];
  int unsigned col_cnt = 0, row_cnt = 0;
  logic [7:0] prev_pix = 0;

  vertex_t pending_vertices[$];
  int errors = 0;
  int idle_cycles = 0;
  bit bursty = 1;
  logic [7:0] last_pix = 0;

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned unit_len(int unsigned a, int unsigned s);
    longint unsigned t, n;
    t = (longint'(a) * a) << 32;
    n = (root64(t / s) + 1) >> 1;
    return n > 32767 ? 32767 : int'(n);
  endfunction

  function automatic logic [15:0] signed_len(int d, int unsigned s);
    int m;
    m = unit_len(d < 0 ? -d : d, s);
    return 16'(d < 0 ? -m : m);
  endfunction

  function automatic logic [26:0] grid_pos(longint steps);
    longint v;
    v = steps * longint'(spacing_reg);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[26:0];
  endfunction

  function automatic vertex_t make_vertex(int row, int col, int ew, int eh,
      int self, int left, int right, int up, int down);
    vertex_t v;
    int dx, dz;
    int unsigned s;
    dx = right - left;
    dz = down - up;
    s = dx * dx + dz * dz + 1;
    v.row = 10'(row);
    v.col = 10'(col);
    v.xp = grid_pos(2 * longint'(col) - ew);
    v.yh = 8'(self);
    v.zp = grid_pos(2 * longint'(row) + 2 - eh);
    v.nx = signed_len(dx, s);
    v.ny = 15'(unit_len(1, s));
    v.nz = signed_len(dz, s);
    v.rl = 0;
    v.fd = 0;
    return v;
  endfunction

  // compute the vertices released by one pixel and queue them
  task automatic predict_vertices(logic [7:0] pix);
    int ew, eh, c, r, lft, rgt, slf;
    bit last_col, last_row;
    vertex_t made[$];
    vertex_t v;
    ew = width_reg;
    eh = height_reg;
    if (ew < 1) ew = 1;
    if (ew > ROW_MAX) ew = ROW_MAX;
    if (eh < 2) eh = 2;
    if (eh > ROW_MAX) eh = ROW_MAX;
    c = col_cnt;
    r = row_cnt;
    if (c >= ROW_MAX) c = ROW_MAX - 1;
    last_col = c >= ew - 1;
    last_row = r >= eh - 1;
    if (r > 0) begin
      slf = newer_line[c];
      lft = c > 0 ? older_line[c - 1] : slf;
      rgt = (!last_col && c + 1 < ROW_MAX) ? newer_line[c + 1] : slf;
      made = {made, make_vertex(r - 1, c, ew, eh, slf, lft, rgt,
                                r > 1 ? older_line[c] : slf, pix)};
    end
    older_line[c] = newer_line[c];
    newer_line[c] = pix;
    if (r > 0 && last_row) begin
      if (c > 0) begin
        slf = prev_pix;
        lft = c > 1 ? newer_line[c - 2] : slf;
        made = {made, make_vertex(r, c - 1, ew, eh, slf, lft, pix,
                                  older_line[c - 1], slf)};
      end
      if (last_col) begin
        lft = c > 0 ? prev_pix : pix;
        v = make_vertex(r, c, ew, eh, pix, lft, pix, older_line[c], pix);
        v.fd = 1;
        made = {made, v};
      end
    end
    if (made.size() > 0) made[made.size() - 1].rl = 1;
    foreach (made[i]) pending_vertices = {pending_vertices, made[i]};
    prev_pix = pix;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else col_cnt = c + 1;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) report("unexpected beat", 1, 0);
      else begin
        e = pending_vertices.pop_front();
        if (vertex_row !== e.row) report("vertex_row", vertex_row, e.row);
        if (vertex_col !== e.col) report("vertex_col", vertex_col, e.col);
        if (x_pos !== e.xp) report("x_pos", x_pos, e.xp);
        if (y_height !== e.yh) report("y_height", y_height, e.yh);
        if (z_pos !== e.zp) report("z_pos", z_pos, e.zp);
        if (normal_x !== e.nx) report("normal_x", normal_x, e.nx);
        if (normal_y !== e.ny) report("normal_y", normal_y, e.ny);
        if (normal_z !== e.nz) report("normal_z", normal_z, e.nz);
        if (run_last !== e.rl) report("run_last", run_last, e.rl);
        if (frame_done !== e.fd) report("frame_done", frame_done, e.fd);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver with random stall bursts
  initial begin
    @(posedge clk);
    out_ready <= 1;
    forever begin
      if (bursty && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1;
      end
      @(posedge clk);
    end
  end

  task automatic send_pixel(logic [7:0] pix);
    if (bursty && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1;
    height_sample <= pix;
    do @(posedge clk); while (!in_ready);
    predict_vertices(pix);
    last_pix = pix;
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_vertices.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_WIDTH:   width_reg = 32'(val[10:0]);
      CFG_HEIGHT:  height_reg = 32'(val[10:0]);
      default:     spacing_reg = 32'(val);
    endcase
  endtask

  // reconfigure between frames once the block has gone quiet
  task automatic set_frame(int w, int h, int sp);
    drain;
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_WIDTH, 16'(w));
    write_reg(CFG_HEIGHT, 16'(h));
    write_reg(CFG_SPACING, 16'(sp));
  endtask

  // change one size register inside a frame once the block has gone quiet
  task automatic retune(cfg_idx_t idx, int val);
    drain;
    repeat (SETTLE) @(posedge clk);
    write_reg(idx, 16'(val));
  endtask

  function automatic int pixels_in_frame();
    int ew, eh;
    ew = width_reg < 1 ? 1 : (width_reg > ROW_MAX ? ROW_MAX : width_reg);
    eh = height_reg < 2 ? 2 : (height_reg > ROW_MAX ? ROW_MAX : height_reg);
    return ew * eh;
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1, 2: return 8'(last_pix + $urandom_range(0, 6) - 3);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mode: 0 random, 1 flat, 2 checkerboard of extremes
  task automatic send_frame(int mode);
    int n;
    n = pixels_in_frame();
    for (int i = 0; i < n; i++)
      case (mode)
        1: send_pixel(8'd128);
        2: send_pixel(i[0] ? 8'd255 : 8'd0);
        default: send_pixel(pick_pixel());
      endcase
  endtask

  task automatic test_directed;
    set_frame(3, 2, 256);
    send_frame(2);
    set_frame(1, 3, 65535);
    send_frame(1);
    set_frame(0, 0, 1);
    send_frame(0);
    set_frame(4, 3, 0);
    send_frame(0);
  endtask

  task automatic test_size_limits;
    // width past the store depth on the first columns of a middle row
    set_frame(5, 3, 65535);
    for (int i = 0; i < 5; i++) send_pixel(pick_pixel());
    retune(CFG_WIDTH, 2047);
    for (int i = 0; i < 4; i++) send_pixel(pick_pixel());
    retune(CFG_WIDTH, 5);
    for (int i = 0; i < 6; i++) send_pixel(pick_pixel());
    // height past the limit, then cut so that row 3 closes the frame
    set_frame(3, 2047, 65535);
    for (int i = 0; i < 9; i++) send_pixel(pick_pixel());
    retune(CFG_HEIGHT, 3);
    for (int i = 0; i < 3; i++) send_pixel(pick_pixel());
  endtask

  task automatic test_drain_pause;
    set_frame(5, 4, 300);
    for (int i = 0; i < 20; i++) begin
      send_pixel(pick_pixel());
      if (i == 8) drain;
    end
  endtask

  task automatic test_random_frames(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      set_frame($urandom_range(1, 9), $urandom_range(2, 5), $urandom_range(0, 65535));
      sent += pixels_in_frame();
      send_frame(0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    test_directed;
    test_drain_pause;
    test_size_limits;
    test_random_frames(120);
    bursty = 0;
    test_random_frames(40);
    drain;
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
